// File: rtl/core/fcr_pkg.sv
// Shared types, constants and register codes of the FAT12 cluster chain reader.
package fcr_pkg;

  // Field widths.
  localparam int unsigned CLUSTER_W = 12;
  localparam int unsigned SHIFT_W   = 4;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // FAT12 chain codes.
  localparam logic [CLUSTER_W-1:0] EOC_LIMIT  = 12'hFF7;
  localparam logic [CLUSTER_W-1:0] LAST_MIN   = 12'hFF8;
  localparam logic [LEN_W-1:0]     ENTRY_MASK = 16'h0FFF;
  localparam logic [ADDR_W-1:0]    FIRST_DATA = 32'd2;

  // Register values after reset.
  localparam logic [SHIFT_W-1:0] SHIFT_RST     = 4'd9;
  localparam logic [ADDR_W-1:0]  FAT_BASE_RST  = 32'd512;
  localparam logic [ADDR_W-1:0]  DATA_BASE_RST = 32'd0;

  typedef enum logic {
    CMD_START  = 1'b0,
    CMD_ANSWER = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_FETCH   = 2'd0,
    KIND_SEGMENT = 2'd1,
    KIND_DONE    = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLUSTER_SHIFT = 2'd0,
    REG_FAT_BASE      = 2'd1,
    REG_DATA_BASE     = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic                 command;
    logic [CLUSTER_W-1:0] start_cluster;
    logic [LEN_W-1:0]     file_size;
    logic [ADDR_W-1:0]    byte_position;
    logic [LEN_W-1:0]     byte_count;
    logic [LEN_W-1:0]     fat_word;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  length;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [SHIFT_W-1:0] cluster_shift;
    logic [ADDR_W-1:0]  fat_base;
    logic [ADDR_W-1:0]  data_base;
  } cfg_t;

  typedef struct packed {
    logic [CLUSTER_W-1:0] cluster;
    logic [ADDR_W-1:0]    skip;
    logic [LEN_W-1:0]     offset;
    logic [LEN_W-1:0]     end_rem;
    logic [LEN_W-1:0]     done;
    logic [LEN_W-1:0]     wanted;
    logic                 busy;
  } state_t;

  // Everything one item produces: up to two results and the next walk state.
  typedef struct packed {
    logic [1:0] count;
    out_item_t  res0;
    out_item_t  res1;
    state_t     state;
  } step_t;

endpackage

// File: rtl/core/fcr_in_if.sv
// Valid/ready channel that carries input items into the reader.
interface fcr_in_if;
  import fcr_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/fcr_out_if.sv
// Valid/ready channel that carries result items out of the reader.
interface fcr_out_if;
  import fcr_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/fcr_step.sv
// Single-pass update of the cluster walk for one input item.
module fcr_step (
  input  fcr_pkg::cfg_t     cfg_i,
  input  fcr_pkg::state_t   state_i,
  input  fcr_pkg::in_item_t item_i,
  input  logic              item_valid_i,
  output fcr_pkg::step_t    step_o
);
  import fcr_pkg::*;

  logic [LEN_W-1:0]     csize;
  logic [LEN_W-1:0]     cmask;
  logic [LEN_W-1:0]     word_sel;
  logic [CLUSTER_W-1:0] next_c;
  logic [LEN_W-1:0]     seg_size;
  logic [LEN_W-1:0]     left;
  logic [LEN_W-1:0]     end_v;
  logic [ADDR_W-1:0]    seg_addr;
  logic                 do_follow;
  logic                 has_seg;
  state_t               st;
  out_item_t            seg;
  out_item_t            fol;

  always_comb begin
    csize    = LEN_W'(1) << cfg_i.cluster_shift;
    cmask    = csize - LEN_W'(1);
    st       = state_i;
    do_follow = 1'b0;
    has_seg  = 1'b0;
    seg      = '0;
    fol      = '0;
    end_v    = '0;
    left     = state_i.wanted - state_i.done;
    seg_size = csize - state_i.offset;
    seg_addr = '0;

    // Odd clusters take the upper 12 bits of the word, even ones the lower.
    word_sel = state_i.cluster[0] ? (item_i.fat_word >> 4) : (item_i.fat_word & ENTRY_MASK);
    next_c   = word_sel[CLUSTER_W-1:0];

    if (item_valid_i) begin
      if (item_i.command == CMD_START) begin
        st.cluster = item_i.start_cluster;
        st.skip    = item_i.byte_position >> cfg_i.cluster_shift;
        st.offset  = item_i.byte_position[LEN_W-1:0] & cmask;
        st.end_rem = item_i.file_size & cmask;
        st.done    = '0;
        st.wanted  = item_i.byte_count;
        st.busy    = 1'b1;
        do_follow  = 1'b1;
      end else if (state_i.busy) begin
        do_follow = 1'b1;
        if (state_i.skip != '0) begin
          st.skip = state_i.skip - ADDR_W'(1);
        end else begin
          // Clamp to the file end on the last cluster; a zero remainder is a full cluster.
          if (next_c >= LAST_MIN) begin
            end_v = (state_i.end_rem == '0) ? csize : state_i.end_rem;
            if (({1'b0, state_i.offset} + {1'b0, seg_size}) > {1'b0, end_v}) begin
              seg_size = (end_v > state_i.offset) ? (end_v - state_i.offset) : '0;
            end
          end
          if (seg_size > left) begin
            seg_size = left;
          end
          seg_addr = cfg_i.data_base
                   + ((ADDR_W'(state_i.cluster) - FIRST_DATA) << cfg_i.cluster_shift)
                   + ADDR_W'(state_i.offset);
          has_seg     = 1'b1;
          seg.kind    = KIND_SEGMENT;
          seg.address = seg_addr;
          seg.length  = seg_size;
          seg.last    = 1'b0;
          st.done     = state_i.done + seg_size;
          st.offset   = '0;
        end
        st.cluster = next_c;
      end
    end

    // Either ask for the next FAT word or close the walk.
    if (do_follow) begin
      fol.last = 1'b1;
      if ((st.done < st.wanted) && (st.cluster < EOC_LIMIT)) begin
        fol.kind    = KIND_FETCH;
        fol.address = cfg_i.fat_base + ADDR_W'(st.cluster) + ADDR_W'(st.cluster[CLUSTER_W-1:1]);
        fol.length  = '0;
      end else begin
        fol.kind    = KIND_DONE;
        fol.address = '0;
        fol.length  = st.done;
        st.busy     = 1'b0;
      end
    end
  end

  always_comb begin
    step_o.state = st;
    if (has_seg) begin
      step_o.count = 2'd2;
      step_o.res0  = seg;
      step_o.res1  = fol;
    end else begin
      step_o.count = do_follow ? 2'd1 : 2'd0;
      step_o.res0  = fol;
      step_o.res1  = '0;
    end
  end

endmodule

// File: rtl/core/fat12_cluster_chain_reader_core.sv
// Top level of the FAT12 cluster chain reader: registers, input stage and result queue.
//
// The reader plans a file read over a FAT12 cluster chain. Input items arrive on
// in_i: a start command loads a new walk and a FAT word answer advances it. Each
// item gives up to two results on out_o: an optional data segment and then either
// the next FAT fetch request or a done result with the total byte count; last
// marks the final result of an item. Answers that arrive with no walk running
// give no result.
// Configuration goes through cfg_we_i, cfg_idx_i and cfg_wdata_i; the user must write it
// only while the block is idle, as the block itself does not enforce it.
// An accepted item is held in an input register and is processed by the single-pass
// update logic, which writes its results into a three-entry result queue once the
// queue has room for all of them; the head of the queue drives out_o.
// The queue drains one result per cycle while the receiver is ready, so items with
// one result run at one per cycle and items with a segment and a follow-up cannot
// be taken at that rate. When the receiver stalls, the queue fills and the input
// register holds its item until there is room for all its results, with in_i.ready
// low meanwhile. Reset loads the register defaults, stops any walk and empties the queue.
module fat12_cluster_chain_reader_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fcr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fcr_pkg::ADDR_W-1:0]    cfg_wdata_i,
  fcr_in_if.sink                        in_i,
  fcr_out_if.source                     out_o
);
  import fcr_pkg::*;

  localparam int unsigned QDEPTH = 3;

  cfg_t       cfg_q;
  state_t     state_q;
  logic       s1_valid_q;
  in_item_t   s1_item_q;
  step_t      step;
  logic       fits;
  logic       consume;
  logic       pop;
  logic [1:0] push_n;
  logic [1:0] wpos;
  logic [1:0] cnt_q;
  logic [1:0] cnt_d;
  out_item_t  q_q [QDEPTH];
  out_item_t  q_d [QDEPTH];
  out_item_t  shifted [QDEPTH];
  out_item_t  fin;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cluster_shift <= SHIFT_RST;
      cfg_q.fat_base      <= FAT_BASE_RST;
      cfg_q.data_base     <= DATA_BASE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CLUSTER_SHIFT: cfg_q.cluster_shift <= cfg_wdata_i[SHIFT_W-1:0];
        REG_FAT_BASE:      cfg_q.fat_base      <= cfg_wdata_i;
        REG_DATA_BASE:     cfg_q.data_base     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Walk update for the item in the input register.
  fcr_step u_step (
    .cfg_i        (cfg_q),
    .state_i      (state_q),
    .item_i       (s1_item_q),
    .item_valid_i (s1_valid_q),
    .step_o       (step)
  );

  // The item leaves the input register once the queue has room for all its results.
  assign fits    = ({1'b0, cnt_q} + {1'b0, step.count}) <= 3'(QDEPTH);
  assign consume = s1_valid_q && fits;
  assign in_i.ready = !s1_valid_q || consume;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_item_q <= in_i.data;
    end
  end

  // Walk state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (consume) begin
      state_q <= step.state;
    end
  end

  // Result queue: the head drives the output, new results land behind the rest.
  assign pop    = (cnt_q != 2'd0) && out_o.ready;
  assign push_n = consume ? step.count : 2'd0;
  assign wpos   = cnt_q - {1'b0, pop};
  assign cnt_d  = cnt_q - {1'b0, pop} + push_n;

  always_comb begin
    shifted[0] = pop ? q_q[1] : q_q[0];
    shifted[1] = pop ? q_q[2] : q_q[1];
    shifted[2] = q_q[2];
    for (int i = 0; i < QDEPTH; i++) begin
      q_d[i] = shifted[i];
      if ((push_n != 2'd0) && (wpos == 2'(i))) begin
        q_d[i] = step.res0;
      end else if ((push_n == 2'd2) && ((wpos + 2'd1) == 2'(i))) begin
        q_d[i] = step.res1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_q[i] <= q_d[i];
    end
  end

  assign out_o.valid = (cnt_q != 2'd0);
  assign out_o.data  = q_q[0];

  // Final result of the item being consumed, for the checks below.
  assign fin = (step.count == 2'd2) ? step.res1 : step.res0;

  // A done result ends the walk.
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && (step.count != 2'd0) && (fin.kind == KIND_DONE)) |=> !state_q.busy)
    else $error("walk still busy after a done result");

  // A fetch request leaves the walk running.
  a_fetch_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && (step.count != 2'd0) && (fin.kind == KIND_FETCH)) |=> state_q.busy)
    else $error("walk stopped after a fetch request");

  // A segment at the head always has its follow-up queued behind it.
  a_seg_pair : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.data.last) |-> ((cnt_q >= 2'd2) && (out_o.data.kind == KIND_SEGMENT)))
    else $error("segment queued without its follow-up");

  // An answer with no walk running gives no result.
  a_idle_answer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && (s1_item_q.command == CMD_ANSWER) && !state_q.busy) |-> (step.count == 2'd0))
    else $error("result from an answer while idle");

endmodule

// File: test/fat12_cluster_chain_reader_core_tb.sv
// Self-checking testbench for the FAT12 cluster chain reader core.
module fat12_cluster_chain_reader_core_tb;
  import fcr_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS = 20;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  reg_idx_e cfg_idx;
  logic [ADDR_W-1:0] cfg_wdata;

  fcr_in_if in_ch ();
  fcr_out_if out_ch ();

  fat12_cluster_chain_reader_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // Register copy, the walk state as the block sees it, and the planner's own copy.
  cfg_t regs;
  state_t walk_state;
  state_t plan_state;

  in_item_t pending_items[$];
  out_item_t awaited_results[$];

  bit steady_run = 1'b0;
  int quiet_cycles = 0;
  int error_count = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int fetch_count = 0;
  int segment_count = 0;
  int empty_segments = 0;
  int walks_ended = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // One item of the chain walk: up to two results and the next state.
  function automatic step_t chain_step(state_t st, cfg_t c, in_item_t it);
    step_t r;
    out_item_t seg;
    out_item_t tail;
    logic [31:0] csize;
    logic [31:0] cmask;
    logic [31:0] seg_len;
    logic [31:0] left_bytes;
    logic [31:0] end_pos;
    logic [CLUSTER_W-1:0] cur;
    logic [CLUSTER_W-1:0] nxt;
    r = '0;
    seg = '0;
    tail = '0;
    csize = 32'd1 << c.cluster_shift;
    cmask = csize - 32'd1;
    if (it.command == CMD_START) begin
      st.cluster = it.start_cluster;
      st.skip = it.byte_position >> c.cluster_shift;
      st.offset = 16'(it.byte_position & cmask);
      st.end_rem = 16'(32'(it.file_size) & cmask);
      st.done = '0;
      st.wanted = it.byte_count;
      st.busy = 1'b1;
    end else if (!st.busy) begin
      // An answer with no walk running leaves everything as it is.
      r.state = st;
      return r;
    end else begin
      cur = st.cluster;
      nxt = cur[0] ? it.fat_word[15:4] : it.fat_word[11:0];
      if (st.skip != '0) begin
        st.skip = st.skip - 32'd1;
      end else begin
        seg_len = csize - 32'(st.offset);
        left_bytes = 32'(st.wanted - st.done);
        // On the last cluster the segment stops at the file end; a zero
        // remainder means the file fills that cluster.
        if (nxt >= LAST_MIN) begin
          end_pos = (st.end_rem == '0) ? csize : 32'(st.end_rem);
          if (32'(st.offset) + seg_len > end_pos) begin
            seg_len = (end_pos > 32'(st.offset)) ? end_pos - 32'(st.offset) : 32'd0;
          end
        end
        if (seg_len > left_bytes) begin
          seg_len = left_bytes;
        end
        seg.kind = KIND_SEGMENT;
        seg.address = c.data_base + ((32'(cur) - FIRST_DATA) << c.cluster_shift)
                      + 32'(st.offset);
        seg.length = seg_len[15:0];
        seg.last = 1'b0;
        r.res0 = seg;
        r.count = 2'd1;
        st.done = st.done + seg_len[15:0];
        st.offset = '0;
      end
      st.cluster = nxt;
    end
    // Either fetch the next FAT word or close the walk.
    if (st.done < st.wanted && st.cluster < EOC_LIMIT) begin
      tail.kind = KIND_FETCH;
      tail.address = c.fat_base + 32'(st.cluster) + 32'(st.cluster >> 1);
      tail.length = '0;
    end else begin
      tail.kind = KIND_DONE;
      tail.address = '0;
      tail.length = st.done;
      st.busy = 1'b0;
    end
    tail.last = 1'b1;
    if (r.count == 2'd0) begin
      r.res0 = tail;
    end else begin
      r.res1 = tail;
    end
    r.count = r.count + 2'd1;
    r.state = st;
    return r;
  endfunction

  // Queue an item for the driver and advance the planner's view of the walk.
  function automatic void push_item(in_item_t it);
    step_t s;
    s = chain_step(plan_state, regs, it);
    plan_state = s.state;
    pending_items.push_back(it);
  endfunction

  function automatic in_item_t start_item(logic [CLUSTER_W-1:0] cluster,
                                          logic [LEN_W-1:0] fsize,
                                          logic [ADDR_W-1:0] pos,
                                          logic [LEN_W-1:0] count);
    in_item_t it;
    it.command = CMD_START;
    it.start_cluster = cluster;
    it.file_size = fsize;
    it.byte_position = pos;
    it.byte_count = count;
    it.fat_word = 16'($urandom);
    return it;
  endfunction

  // Unused fields of an answer carry random bits.
  function automatic in_item_t answer_item(logic [LEN_W-1:0] word);
    in_item_t it;
    it.command = CMD_ANSWER;
    it.start_cluster = 12'($urandom);
    it.file_size = 16'($urandom);
    it.byte_position = $urandom;
    it.byte_count = 16'($urandom);
    it.fat_word = word;
    return it;
  endfunction

  // Place the next cluster in the half of the word that the current cluster selects.
  function automatic logic [LEN_W-1:0] answer_word(logic [CLUSTER_W-1:0] cur,
                                                   logic [CLUSTER_W-1:0] nxt);
    logic [LEN_W-1:0] w;
    w = 16'($urandom);
    if (cur[0]) begin
      w[15:4] = nxt;
    end else begin
      w[11:0] = nxt;
    end
    return w;
  endfunction

  function automatic logic [CLUSTER_W-1:0] pick_next();
    int roll;
    roll = $urandom_range(99);
    if (roll < 15) return 12'($urandom_range(12'hFF8, 12'hFFF));
    if (roll < 18) return EOC_LIMIT;
    if (roll < 22) return 12'($urandom);
    return 12'($urandom_range(2, 12'hFEF));
  endfunction

  function automatic in_item_t random_start();
    logic [31:0] csize;
    logic [31:0] cnt;
    logic [CLUSTER_W-1:0] cluster;
    logic [LEN_W-1:0] fsize;
    logic [ADDR_W-1:0] pos;
    int roll;
    csize = 32'd1 << regs.cluster_shift;
    roll = $urandom_range(99);
    if (roll < 5) cluster = 12'($urandom_range(12'hFF7, 12'hFFF));
    else if (roll < 15) cluster = 12'($urandom);
    else cluster = 12'($urandom_range(2, 12'hFEF));
    fsize = 16'($urandom);
    if ($urandom_range(3) == 0) fsize = fsize & ~16'(csize - 32'd1);
    roll = $urandom_range(99);
    if (roll < 10) pos = $urandom;
    else if (roll < 20) pos = '0;
    else pos = $urandom_range(0, 3) * csize + ($urandom & (csize - 32'd1));
    roll = $urandom_range(99);
    if (roll < 5) begin
      cnt = 32'd0;
    end else if (roll < 50) begin
      cnt = $urandom_range(1, 4 * csize);
      if (cnt > 32'hFFFF) cnt = 32'hFFFF;
    end else begin
      cnt = 32'($urandom_range(0, 16'hFFFF));
    end
    return start_item(cluster, fsize, pos, cnt[15:0]);
  endfunction

  // Mostly whole walks with random chains; some stray answers and abandoned walks.
  function automatic void plan_walks(int target);
    int made;
    made = 0;
    while (made < target) begin
      if (!plan_state.busy && $urandom_range(99) < 8) begin
        push_item(answer_item(16'($urandom)));
        continue;
      end
      push_item(random_start());
      made++;
      while (plan_state.busy && made < target) begin
        if ($urandom_range(99) < 4) break;
        push_item(answer_item(answer_word(plan_state.cluster, pick_next())));
        made++;
      end
    end
  endfunction

  // An end-of-chain answer closes any running walk before registers change.
  function automatic void close_walk();
    if (plan_state.busy) begin
      push_item(answer_item(answer_word(plan_state.cluster, 12'hFFF)));
    end
  endfunction

  // Wait until every queued item is taken and every result is back.
  task automatic settle();
    while (pending_items.size() != 0 || in_ch.valid || awaited_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_regs(logic [SHIFT_W-1:0] shift, logic [ADDR_W-1:0] fat,
                           logic [ADDR_W-1:0] data);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= REG_CLUSTER_SHIFT;
    cfg_wdata <= 32'(shift);
    @(posedge clk_i);
    cfg_idx <= REG_FAT_BASE;
    cfg_wdata <= fat;
    @(posedge clk_i);
    cfg_idx <= REG_DATA_BASE;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    regs.cluster_shift = shift;
    regs.fat_base = fat;
    regs.data_base = data;
  endtask

  // Input driver: predicts the results of each transfer and offers the next item.
  always @(posedge clk_i) begin : drive_items
    step_t s;
    bit offer;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        s = chain_step(walk_state, regs, in_ch.data);
        walk_state = s.state;
        if (s.count >= 2'd1) awaited_results.push_back(s.res0);
        if (s.count == 2'd2) awaited_results.push_back(s.res1);
        items_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        offer = pending_items.size() != 0 && (steady_run || $urandom_range(99) >= 15);
        if (offer) begin
          in_ch.data <= pending_items.pop_front();
        end
        in_ch.valid <= offer;
      end
    end
  end

  // Result monitor: each transfer is checked against the oldest expectation.
  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_checked++;
        if (awaited_results.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("%0t: unexpected result: expected none, actual kind %0d addr %h len %0d last %0d",
                     $time, out_ch.data.kind, out_ch.data.address, out_ch.data.length,
                     out_ch.data.last);
          end
        end else begin
          want = awaited_results.pop_front();
          if (out_ch.data.kind !== want.kind || out_ch.data.address !== want.address ||
              out_ch.data.length !== want.length || out_ch.data.last !== want.last) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display("%0t: result mismatch: expected kind %0d addr %h len %0d last %0d",
                       $time, want.kind, want.address, want.length, want.last);
              $display("%0t:                  actual   kind %0d addr %h len %0d last %0d",
                       $time, out_ch.data.kind, out_ch.data.address, out_ch.data.length,
                       out_ch.data.last);
            end
          end
          case (want.kind)
            KIND_FETCH: fetch_count++;
            KIND_SEGMENT: begin
              segment_count++;
              if (want.length == '0) empty_segments++;
            end
            default: walks_ended++;
          endcase
        end
      end
      out_ch.ready <= steady_run || $urandom_range(99) >= 15;
    end
  end

  // Cycles since the last transfer on either channel.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("%0t: no transfer for %0d cycles, %0d results still awaited",
             $time, QUIET_LIMIT, awaited_results.size());
    $display("fat12_cluster_chain_reader_core_tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_CLUSTER_SHIFT;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    regs.cluster_shift = SHIFT_RST;
    regs.fat_base = FAT_BASE_RST;
    regs.data_base = DATA_BASE_RST;
    walk_state = '0;
    plan_state = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed cases with the register defaults.
    push_item(answer_item(16'hFFFF));
    push_item(start_item(12'd2, 16'd0, 32'd0, 16'd0));
    push_item(start_item(EOC_LIMIT, 16'hFFFF, 32'd0, 16'd100));
    push_item(start_item(12'hFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF));
    // Whole file of three clusters, ending on a cluster boundary.
    push_item(start_item(12'd2, 16'd1536, 32'd0, 16'hFFFF));
    push_item(answer_item(16'hF003));
    push_item(answer_item(16'h004F));
    push_item(answer_item(16'h0FFF));
    // Position and file end both inside the second cluster.
    push_item(start_item(12'd5, 16'd700, 32'd600, 16'hFFFF));
    push_item(answer_item(16'h0060));
    push_item(answer_item(16'hAFF8));
    // Position past the file end on the last cluster gives an empty segment.
    push_item(start_item(12'd7, 16'd50, 32'd100, 16'd10));
    push_item(answer_item(16'hFFF0));
    // A new start drops the running walk; a bad cluster then ends the chain.
    push_item(start_item(12'd10, 16'd4000, 32'd0, 16'd1000));
    push_item(start_item(12'd3, 16'd4000, 32'd0, 16'd1000));
    push_item(answer_item(16'hFF75));
    // Clusters below two wrap the segment address.
    push_item(start_item(12'd0, 16'd0, 32'd0, 16'd20));
    push_item(answer_item(16'h5001));
    push_item(start_item(12'd1, 16'd0, 32'd0, 16'd600));
    push_item(answer_item(16'h000A));
    push_item(answer_item(16'hFFFF));
    // Largest position: every cluster is skipped.
    push_item(start_item(12'd4, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF));
    push_item(answer_item(16'h3FF8));
    settle();

    // Largest clusters and all-ones bases; the sender stops halfway for a full drain.
    load_regs(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    plan_walks(130);
    settle();
    plan_walks(130);
    close_walk();
    settle();

    // Smallest clusters and zero bases, with no idle cycles on either side.
    load_regs(4'd9, 32'd0, 32'd0);
    steady_run = 1'b1;
    plan_walks(260);
    close_walk();
    settle();
    steady_run = 1'b0;

    load_regs(4'($urandom_range(10, 14)), $urandom, $urandom);
    plan_walks(260);
    close_walk();
    settle();

    load_regs(4'd12, $urandom, $urandom);
    plan_walks(250);
    close_walk();
    settle();

    $display("Run covered %0d input items and %0d results under five register settings.",
             items_accepted, results_checked);
    $display("Results: %0d FAT fetches, %0d segments (%0d empty), %0d finished walks.",
             fetch_count, segment_count, empty_segments, walks_ended);
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("fat12_cluster_chain_reader_core_tb: done, clean");
    end else begin
      $display("fat12_cluster_chain_reader_core_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/fcr_pkg.sv
rtl/core/fcr_in_if.sv
rtl/core/fcr_out_if.sv
rtl/core/fcr_step.sv
rtl/core/fat12_cluster_chain_reader_core.sv
test/fat12_cluster_chain_reader_core_tb.sv
